[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/hsc_pkg.sv]
// Package with widths, constants, bus types and the tanh table function.
`default_nettype none

package hsc_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int ALPHA_W   = 16;
	localparam int X_W       = 24;
	localparam int TV_W      = 23;
	localparam int FRAC_W    = 16;
	localparam int MCAND_W   = 32;
	localparam int MPLIER_W  = 24;
	localparam int ACC_W     = MCAND_W + 1;
	localparam int CNT_W     = 5;
	localparam int GAIN_IN_W = 17;

	localparam logic [ALPHA_W-1:0]   ALPHA_RST  = 16'd739;
	localparam logic [GAIN_IN_W-1:0] GAIN_IN    = 17'd88474;
	localparam logic [MCAND_W-1:0]   GAIN_OUT   = 32'd1975620731;
	localparam logic [SAMPLE_W-2:0]  FULL_SCALE = 15'h7fff;

	typedef struct packed {
		logic                start;
		logic [CNT_W-1:0]    nbits;
		logic [MCAND_W-1:0]  mcand;
		logic [MPLIER_W-1:0] mplier;
	} smul_req_t;

	typedef struct packed {
		logic                done;
		logic [ACC_W-1:0]    acc;
		logic [MPLIER_W-1:0] lo;
	} smul_rsp_t;

	// Restoring division, used only while the table is elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		int          j;
		q = '0;
		r = '0;
		for (j = 63; j >= 0; j--) begin
			r = {r[63:0], a[j]};
			if (r >= {1'b0, b}) begin
				r    = r - {1'b0, b};
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry i of an n-interval tanh table over [0, 4) in Q0.22.
	function automatic logic [TV_W-1:0] tanh_entry(input logic [63:0] n, input logic [63:0] i);
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] num;
		logic [63:0] den;
		int          k;
		int          r;
		s    = udiv64(i * (64'd1 << 25) + (n >> 1), n);
		term = 64'd1 << 30;
		acc  = 64'd1 << 30;
		for (k = 1; k <= 6; k++) begin
			term = udiv64((term * s + (64'd1 << 29)) >> 30, 64'(k));
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		for (r = 0; r < 8; r++)
			acc = (acc * acc + (64'd1 << 29)) >> 30;
		num = ((64'd1 << 30) - acc) << 22;
		den = (64'd1 << 30) + acc;
		return TV_W'(udiv64(num + (den >> 1), den));
	endfunction

endpackage

`default_nettype wire

[rtl/hsc_if.sv]
// Stream interfaces for the audio input and output channels.
`default_nettype none

interface hsc_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [hsc_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface hsc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [hsc_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[rtl/hsc_smul.sv]
// Bit-serial multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
`default_nettype none

module hsc_smul (
	input  logic                clk,
	input  logic                arst_n,
	input  hsc_pkg::smul_req_t  req,
	output hsc_pkg::smul_rsp_t  rsp
);
	import hsc_pkg::*;

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [MPLIER_W-1:0] lo_q;
	logic [MCAND_W-1:0]  mcand_q;
	logic [ACC_W:0]      sum;

	assign sum = {acc_q[ACC_W-1], acc_q}
		+ (lo_q[0] ? {{2{mcand_q[MCAND_W-1]}}, mcand_q} : {(ACC_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= '0;
			lo_q    <= req.mplier;
			mcand_q <= req.mcand;
		end else if (run_q) begin
			acc_q <= sum[ACC_W:1];
			lo_q  <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;
	assign rsp.lo   = lo_q;

endmodule

`default_nettype wire

[rtl/highpass_softclip_audio.sv]
// Top level: one-pole high-pass filter followed by a tanh soft clipper.
//
// Samples arrive on audio_in and results leave on audio_out, both valid/ready
// streams; a transaction completes when valid and ready are high at a clock edge.
// cfg_we with cfg_wdata writes the high-pass coefficient (unsigned Q0.16); zero
// bypasses the filter and clears the low-pass level. Write it only while idle.
// Each sample is worked through five products (four with the filter bypassed)
// on one bit-serial multiplier that retires one multiplier bit per cycle, plus
// two table reads. One sample is processed at a time, and audio_in is ready
// again in the cycle after the result is loaded into the output register.
// When the receiver stalls, the result waits in the output register and the next
// sample is still accepted; a second finished result waits in the core until the
// register frees up.
// Reset sets the coefficient to 739, clears the low-pass level and empties the
// output register.
`default_nettype none

module highpass_softclip_audio #(
	parameter int TANH_TABLE_ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [hsc_pkg::ALPHA_W-1:0]  cfg_wdata,
	hsc_in_if.sink                       audio_in,
	hsc_out_if.source                    audio_out
);
	import hsc_pkg::*;

	localparam int NB     = $clog2(TANH_TABLE_ENTRIES + 1);
	localparam int IDXR_W = ACC_W + NB - 24;
	localparam logic [IDXR_W-1:0] N_WIDE   = IDXR_W'(TANH_TABLE_ENTRIES);
	localparam logic [NB-1:0]     N_IDX    = NB'(TANH_TABLE_ENTRIES);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_FILT   = 11'b000_0000_0010,
		S_HEAD   = 11'b000_0000_0100,
		S_GAIN   = 11'b000_0000_1000,
		S_SCALE  = 11'b000_0001_0000,
		S_RD0    = 11'b000_0010_0000,
		S_RD1    = 11'b000_0100_0000,
		S_DIFF   = 11'b000_1000_0000,
		S_INTERP = 11'b001_0000_0000,
		S_FINAL  = 11'b010_0000_0000,
		S_WAIT   = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	state_t              state_nxt;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [X_W-1:0]      level_q;
	logic                out_vld_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic [X_W-1:0]      x_q;
	logic                neg_q;
	logic [NB-1:0]       idx_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [TV_W-1:0]     base_q;
	logic [TV_W-1:0]     rom_q;
	logic [SAMPLE_W-1:0] res_q;

	smul_req_t           mreq;
	smul_rsp_t           mrsp;

	logic                in_fire;
	logic                out_load;
	logic [X_W-1:0]      x_in;
	logic [X_W-1:0]      d_in;
	logic [X_W-1:0]      h;
	logic [X_W-1:0]      mag;
	logic [ACC_W-1:0]    step_rnd;
	logic [X_W-1:0]      level_nxt;
	logic [ACC_W:0]      u_sum;
	logic [X_W-1:0]      u;
	logic [ACC_W+NB-1:0] p_full;
	logic [IDXR_W-1:0]   idx_raw;
	logic [NB-1:0]       idx_up;
	logic [NB-1:0]       rom_addr;
	logic [X_W-1:0]      diff;
	logic [ACC_W-1:0]    t_full;
	logic [TV_W-1:0]     t_val;
	logic [17:0]         y_raw;
	logic [SAMPLE_W-2:0] y_mag;
	logic [SAMPLE_W-1:0] y_val;
	logic [TV_W-1:0]     rom_w [TANH_TABLE_ENTRIES+1];

	for (genvar g = 0; g <= TANH_TABLE_ENTRIES; g++) begin : g_rom
		localparam logic [TV_W-1:0] ENTRY = tanh_entry(64'(TANH_TABLE_ENTRIES), 64'(g));
		assign rom_w[g] = ENTRY;
	end

	hsc_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign audio_in.ready   = (state_q == S_IDLE);
	assign in_fire          = audio_in.valid && (state_q == S_IDLE);
	assign out_load         = (state_q == S_WAIT) && (!out_vld_q || audio_out.ready);
	assign audio_out.valid  = out_vld_q;
	assign audio_out.sample_out = out_data_q;

	assign x_in      = {audio_in.sample_in[SAMPLE_W-1], audio_in.sample_in, 7'b0};
	assign d_in      = x_in - level_q;
	assign h         = x_q - level_q;
	assign mag       = h[X_W-1] ? (X_W'(0) - h) : h;
	assign step_rnd  = mrsp.acc + ACC_W'(mrsp.lo[MPLIER_W-1]);
	assign level_nxt = level_q + step_rnd[X_W-1:0];
	assign u_sum     = {mrsp.acc, mrsp.lo[MPLIER_W-1]} + (ACC_W+1)'(mrsp.lo[MPLIER_W-2]);
	assign u         = u_sum[X_W-1:0];
	assign p_full    = {mrsp.acc, mrsp.lo[MPLIER_W-1 -: NB]};
	assign idx_raw   = p_full[ACC_W+NB-1:24];
	assign idx_up    = (idx_q == N_IDX) ? idx_q : idx_q + NB'(1);
	assign rom_addr  = (state_q == S_RD1) ? idx_up : idx_q;
	assign diff      = {1'b0, rom_q} - {1'b0, base_q};
	assign t_full    = ACC_W'(base_q) + step_rnd;
	assign t_val     = t_full[ACC_W-1] ? '0 : t_full[TV_W-1:0];
	assign y_raw     = mrsp.acc[32:15] + 18'(mrsp.acc[14]);
	assign y_mag     = (y_raw > 18'(FULL_SCALE)) ? FULL_SCALE : y_raw[SAMPLE_W-2:0];
	assign y_val     = neg_q ? (SAMPLE_W'(0) - {1'b0, y_mag}) : {1'b0, y_mag};

	always_comb begin
		state_nxt = state_q;
		mreq      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (alpha_q != '0) begin
						mreq.start  = 1'b1;
						mreq.nbits  = CNT_W'(ALPHA_W);
						mreq.mcand  = {{(MCAND_W-X_W){d_in[X_W-1]}}, d_in};
						mreq.mplier = MPLIER_W'(alpha_q);
						state_nxt   = S_FILT;
					end else begin
						state_nxt = S_HEAD;
					end
				end
			end
			S_FILT: begin
				if (mrsp.done)
					state_nxt = S_HEAD;
			end
			S_HEAD: begin
				mreq.start  = 1'b1;
				mreq.nbits  = CNT_W'(GAIN_IN_W);
				mreq.mcand  = MCAND_W'(mag);
				mreq.mplier = MPLIER_W'(GAIN_IN);
				state_nxt   = S_GAIN;
			end
			S_GAIN: begin
				if (mrsp.done) begin
					mreq.start  = 1'b1;
					mreq.nbits  = CNT_W'(NB);
					mreq.mcand  = MCAND_W'(u);
					mreq.mplier = MPLIER_W'(TANH_TABLE_ENTRIES);
					state_nxt   = S_SCALE;
				end
			end
			S_SCALE: begin
				if (mrsp.done)
					state_nxt = S_RD0;
			end
			S_RD0: begin
				state_nxt = S_RD1;
			end
			S_RD1: begin
				state_nxt = S_DIFF;
			end
			S_DIFF: begin
				mreq.start  = 1'b1;
				mreq.nbits  = CNT_W'(FRAC_W);
				mreq.mcand  = {{(MCAND_W-X_W){diff[X_W-1]}}, diff};
				mreq.mplier = MPLIER_W'(frac_q);
				state_nxt   = S_INTERP;
			end
			S_INTERP: begin
				if (mrsp.done) begin
					mreq.start  = 1'b1;
					mreq.nbits  = CNT_W'(TV_W);
					mreq.mcand  = GAIN_OUT;
					mreq.mplier = MPLIER_W'(t_val);
					state_nxt   = S_FINAL;
				end
			end
			S_FINAL: begin
				if (mrsp.done)
					state_nxt = S_WAIT;
			end
			S_WAIT: begin
				if (out_load)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			alpha_q   <= ALPHA_RST;
			level_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
				if (cfg_wdata == '0)
					level_q <= '0;
			end else if ((state_q == S_FILT) && mrsp.done) begin
				level_q <= level_nxt;
			end
			if (out_load)
				out_vld_q <= 1'b1;
			else if (audio_out.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= rom_w[rom_addr];
		if (in_fire)
			x_q <= x_in;
		if (state_q == S_HEAD)
			neg_q <= h[X_W-1];
		if ((state_q == S_SCALE) && mrsp.done) begin
			idx_q  <= (idx_raw >= N_WIDE) ? N_IDX : idx_raw[NB-1:0];
			frac_q <= p_full[23:8];
		end
		if (state_q == S_RD1)
			base_q <= rom_q;
		if ((state_q == S_FINAL) && mrsp.done)
			res_q <= y_val;
		if (out_load)
			out_data_q <= res_q;
	end

endmodule

`default_nettype wire

[rtl/hsc_checker.sv]
// Port-level checker for the high-pass soft clipper and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module hsc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [hsc_pkg::SAMPLE_W-1:0] sample_out
);

	// A stalled result keeps its value until the transaction completes.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out))

	// Only one sample is in the core at a time.
	`ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

	// A new result never shows up in the cycle right after an input transaction.
	`ASSERT_NEXT(a_no_early_out, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

	// Loading a result frees the core for the next sample in the same edge.
	`ASSERT_IMPLY(a_ready_on_load, clk, arst_n, $rose(out_valid), in_ready)

endmodule

bind highpass_softclip_audio hsc_checker u_hsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (audio_in.valid),
	.in_ready   (audio_in.ready),
	.out_valid  (audio_out.valid),
	.out_ready  (audio_out.ready),
	.sample_out (audio_out.sample_out)
);

`default_nettype wire
